// ===== rtl/esp_pkg.sv =====
// ----------------------------------------------------------------------------
// esp_pkg: shared definitions for the encoder speed and position block
// Widths, register indexes, operation codes, scale constants, sequencer
// states and the divider status word.
// ----------------------------------------------------------------------------
package esp_pkg;

	localparam int TOTAL_W   = 32;
	localparam int OUT_W     = 32;
	localparam int CPR_W     = 16;
	localparam int PER_W     = 20;
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 2;
	localparam int FUNC_W    = 2;
	localparam int DELTA_W   = 16;
	localparam int CMODE_W   = 2;

	// divider: 64-bit dividend, 36-bit divisor, 32 quotient bits
	localparam int NUM_W = 64;
	localparam int DEN_W = 36;
	localparam int QUO_W = 32;
	localparam int CNT_W = $clog2(QUO_W + 1);

	// shared signed multiplier
	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;

	// filter accumulator
	localparam int SUM_W = 50;
	localparam int FRAC_SH = 16;

	localparam logic [CFG_IDX_W-1:0] REG_CPR    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

	localparam logic [FUNC_W-1:0] FN_SPEED = 2'd0;
	localparam logic [FUNC_W-1:0] FN_POS   = 2'd1;
	localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd2;

	localparam logic [CMODE_W-1:0] CM_X4   = 2'd0;
	localparam logic [CMODE_W-1:0] CM_X1   = 2'd1;
	localparam logic [CMODE_W-1:0] CM_DEG  = 2'd2;
	localparam logic [CMODE_W-1:0] CM_ZERO = 2'd3;

	localparam logic [CPR_W-1:0] CPR_RESET = 16'd1;
	localparam logic [PER_W-1:0] PER_RESET = 20'd1000;

	// 60 s * 1e6 us * 256 (Q24.8) / 4 (x4 decode)
	localparam logic [MUL_W-1:0] RPM_SCALE = MUL_W'(64'd3840000000);
	// 360 degrees / 4 (x4 decode)
	localparam logic [MUL_W-1:0] DEG_SCALE = MUL_W'(64'd90);
	// Q0.16 filter coefficients, 0.854 and 0.0728
	localparam logic [MUL_W-1:0] COEF_A = MUL_W'(64'd55968);
	localparam logic [MUL_W-1:0] COEF_B = MUL_W'(64'd4771);
	localparam int ROUND_HALF = 32768;

	localparam logic [OUT_W-1:0] MAG_CAP = 32'h8000_0000;
	localparam logic [OUT_W-1:0] S32_MAX = 32'h7FFF_FFFF;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACC,
		ST_CNT,
		ST_POS,
		ST_MULD,
		ST_MULN,
		ST_DIVS,
		ST_DIVW,
		ST_RES,
		ST_FILT1,
		ST_FILT2,
		ST_FILT3,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} div_stat_t;

endpackage

// ===== rtl/esp_div.sv =====
// ----------------------------------------------------------------------------
// esp_div: serial restoring divider
// One quotient bit per cycle, 32 bits. A quotient of 2^32 or more is flagged
// as overflow up front and skips the iteration.
// ----------------------------------------------------------------------------
module esp_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [esp_pkg::NUM_W-1:0]  num,
	input  logic [esp_pkg::DEN_W-1:0]  den,
	output logic [esp_pkg::QUO_W-1:0]  quo,
	output esp_pkg::div_stat_t         stat
);
	import esp_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic             ovf_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] lo_q;
	logic [QUO_W-1:0] quo_q;

	logic [QUO_W-1:0] num_hi;
	logic             ovf_in;
	logic [DEN_W+1:0] trial;
	logic             fits;

	assign num_hi = num[NUM_W-1:QUO_W];
	// high half must stay below the divisor, else the quotient needs 33+ bits
	assign ovf_in = DEN_W'(num_hi) >= den;
	assign trial  = {1'b0, rem_q, lo_q[QUO_W-1]} - {2'b00, den_q};
	assign fits   = !trial[DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !ovf_in;
				done_q <= ovf_in;
				ovf_q  <= ovf_in;
				cnt_q  <= CNT_W'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(num_hi);
			lo_q  <= num[QUO_W-1:0];
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= trial[DEN_W-1:0];
			end else begin
				rem_q <= {rem_q[DEN_W-2:0], lo_q[QUO_W-1]};
			end
			quo_q <= {quo_q[QUO_W-2:0], fits};
			lo_q  <= {lo_q[QUO_W-2:0], 1'b0};
		end
	end

	assign quo       = quo_q;
	assign stat.done = done_q;
	assign stat.ovf  = ovf_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q < den_q))
		else $error("partial remainder not below divisor");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("done held longer than one cycle");

	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(start))
		else $error("divider went busy without start");

	a_ovf_skips: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> !busy_q)
		else $error("overflow case still iterating");

endmodule

// ===== rtl/encoder_speed_position.sv =====
// ----------------------------------------------------------------------------
// encoder_speed_position: quadrature speed and position with low-pass filter
// Keeps a running x4 count total, turns it into RPM (Q24.8) on a speed
// sample and filters it, reports position in x4, x1 or degrees, or clears the total.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid/in_stall) carries func, timer_delta, pos_format.
//  One word at a time: in_stall is high from acceptance until the result is
//  placed in the output register. Output channel (out_valid/out_stall) holds
//  position_value, speed_raw and speed_filtered; a new input word is taken
//  while a finished result still waits there.
//  Speed samples and degree reads wait for the serial divider; a saturating
//  quotient skips its iterations. Other words do not use the divider.
//  The shared 33x33 multiplier forms period*cpr, the scaled dividend and both
//  filter products, one per cycle, each registered. The user must write
//  configuration (cfg_we, cfg_index, cfg_data) only while idle; the block
//  itself does not enforce this.
//  Reset: cpr 1, period 1000 us, mode 0, totals and speeds zero, no output.
//  A stalled output holds its word; the sequencer waits in its last state.
// ----------------------------------------------------------------------------
module encoder_speed_position (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [esp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [esp_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [esp_pkg::FUNC_W-1:0]           func,
	input  logic signed [esp_pkg::DELTA_W-1:0]   timer_delta,
	input  logic [esp_pkg::CMODE_W-1:0]          pos_format,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [esp_pkg::OUT_W-1:0]     position_value,
	output logic signed [esp_pkg::OUT_W-1:0]     speed_raw,
	output logic signed [esp_pkg::OUT_W-1:0]     speed_filtered
);
	import esp_pkg::*;

	state_t state_q, state_d;

	logic [CPR_W-1:0] cpr_q;
	logic [PER_W-1:0] per_q;
	logic             smode_q;

	logic [TOTAL_W-1:0]      total_q;
	logic [TOTAL_W-1:0]      prev_total_q;
	logic signed [OUT_W-1:0] prev_speed_q;
	logic signed [OUT_W-1:0] filt_q;

	logic [FUNC_W-1:0]         func_q;
	logic signed [DELTA_W-1:0] delta_q;
	logic [CMODE_W-1:0]        cmode_q;
	logic                      sign_q;
	logic [TOTAL_W-1:0]        mag_q;
	logic [DEN_W-1:0]          d_q;
	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [SUM_W-1:0]   acc_q;
	logic signed [OUT_W-1:0]   raw_q;
	logic signed [OUT_W-1:0]   pos_q;

	logic                    out_valid_q;
	logic signed [OUT_W-1:0] position_value_q;
	logic signed [OUT_W-1:0] speed_raw_q;
	logic signed [OUT_W-1:0] speed_filtered_q;

	logic [CPR_W-1:0]         cpr_eff;
	logic [PER_W-1:0]         per_eff;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	logic                     div_start;
	logic [QUO_W-1:0]         div_quo;
	div_stat_t                div_stat;
	logic                     out_load;

	logic [TOTAL_W-1:0]       cnt_val;
	logic [TOTAL_W-1:0]       cnt_mag;
	logic [TOTAL_W-1:0]       tot_mag;
	logic [TOTAL_W-1:0]       x1_mag;
	logic [OUT_W-1:0]         mag_c;
	logic [OUT_W-1:0]         res_val;
	logic signed [SUM_W-1:0]  sum_fl, rnd_fl;
	logic signed [SUM_W-FRAC_SH-1:0] y_fl;
	logic                     y_fits;
	logic signed [OUT_W-1:0]  filt_next;

	// zero in a register acts as one
	assign cpr_eff = (cpr_q == '0) ? CPR_W'(1) : cpr_q;
	assign per_eff = (per_q == '0) ? PER_W'(1) : per_q;

	assign prod = mul_a * mul_b;

	assign cnt_val = smode_q ? (total_q - prev_total_q) : total_q;
	assign cnt_mag = cnt_val[TOTAL_W-1] ? (TOTAL_W'(0) - cnt_val) : cnt_val;
	assign tot_mag = total_q[TOTAL_W-1] ? (TOTAL_W'(0) - total_q) : total_q;
	assign x1_mag  = tot_mag >> 2;

	// quotient capped at 2^31, then signed and saturated
	assign mag_c   = (div_stat.ovf || (div_quo > MAG_CAP)) ? MAG_CAP : div_quo;
	assign res_val = sign_q ? (OUT_W'(0) - mag_c) : ((mag_c == MAG_CAP) ? S32_MAX : mag_c);

	// y = floor((a*y + b*(x + xprev) + 0.5) / 2^16), saturated
	assign sum_fl = acc_q + SUM_W'(prod_s1);
	assign rnd_fl = sum_fl + SUM_W'(ROUND_HALF);
	assign y_fl   = rnd_fl[SUM_W-1:FRAC_SH];
	assign y_fits = (&y_fl[SUM_W-FRAC_SH-1:OUT_W-1]) || !(|y_fl[SUM_W-FRAC_SH-1:OUT_W-1]);
	assign filt_next = y_fits ? y_fl[OUT_W-1:0] :
		(y_fl[SUM_W-FRAC_SH-1] ? MAG_CAP : S32_MAX);

	esp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod_s1[NUM_W-1:0]),
		.den    (d_q),
		.quo    (div_quo),
		.stat   (div_stat)
	);

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		div_start = 1'b0;
		out_load  = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) state_d = ST_ACC;
			end
			ST_ACC: begin
				priority if (func_q == FN_SPEED) state_d = ST_CNT;
				else if (func_q == FN_POS) state_d = ST_POS;
				else state_d = ST_DONE;
			end
			ST_CNT: state_d = ST_MULD;
			ST_POS: state_d = (cmode_q == CM_DEG) ? ST_MULN : ST_DONE;
			ST_MULD: begin
				mul_a   = MUL_W'(per_eff);
				mul_b   = MUL_W'(cpr_eff);
				state_d = ST_MULN;
			end
			ST_MULN: begin
				mul_a   = MUL_W'(mag_q);
				mul_b   = (func_q == FN_SPEED) ? RPM_SCALE : DEG_SCALE;
				state_d = ST_DIVS;
			end
			ST_DIVS: begin
				div_start = 1'b1;
				state_d   = ST_DIVW;
			end
			ST_DIVW: if (div_stat.done) state_d = ST_RES;
			ST_RES: state_d = (func_q == FN_SPEED) ? ST_FILT1 : ST_DONE;
			ST_FILT1: begin
				mul_a   = MUL_W'(filt_q);
				mul_b   = COEF_A;
				state_d = ST_FILT2;
			end
			ST_FILT2: begin
				mul_a   = MUL_W'(raw_q) + MUL_W'(prev_speed_q);
				mul_b   = COEF_B;
				state_d = ST_FILT3;
			end
			ST_FILT3: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			cpr_q        <= CPR_RESET;
			per_q        <= PER_RESET;
			smode_q      <= 1'b0;
			total_q      <= '0;
			prev_total_q <= '0;
			prev_speed_q <= '0;
			filt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == REG_CPR) cpr_q <= cfg_data[CPR_W-1:0];
				if (cfg_index == REG_PERIOD) per_q <= cfg_data[PER_W-1:0];
				if (cfg_index == REG_MODE) smode_q <= cfg_data[0];
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			if (state_q == ST_ACC) begin
				if (func_q == FN_SPEED || func_q == FN_POS) begin
					total_q <= total_q + TOTAL_W'(delta_q);
				end else if (func_q == FN_CLEAR) begin
					total_q <= '0;
				end
			end
			if (state_q == ST_FILT3) begin
				filt_q       <= filt_next;
				prev_speed_q <= raw_q;
				if (smode_q) prev_total_q <= total_q;
				else total_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			func_q  <= func;
			delta_q <= timer_delta;
			cmode_q <= pos_format;
		end
		if (state_q == ST_ACC) pos_q <= '0;
		if (state_q == ST_CNT) begin
			sign_q <= cnt_val[TOTAL_W-1];
			mag_q  <= cnt_mag;
		end
		if (state_q == ST_POS) begin
			sign_q <= total_q[TOTAL_W-1];
			mag_q  <= tot_mag;
			unique case (cmode_q)
				CM_X4:   pos_q <= OUT_W'(total_q);
				CM_X1:   pos_q <= total_q[TOTAL_W-1] ? OUT_W'(TOTAL_W'(0) - x1_mag) : OUT_W'(x1_mag);
				CM_DEG:  pos_q <= '0;
				CM_ZERO: pos_q <= '0;
				default: pos_q <= '0;
			endcase
		end
		if (state_q == ST_MULD || state_q == ST_MULN ||
		    state_q == ST_FILT1 || state_q == ST_FILT2) begin
			prod_s1 <= prod;
		end
		if (state_q == ST_MULN) begin
			d_q <= (func_q == FN_SPEED) ? prod_s1[DEN_W-1:0] : DEN_W'(cpr_eff);
		end
		if (state_q == ST_RES) begin
			if (func_q == FN_SPEED) raw_q <= res_val;
			else pos_q <= res_val;
		end
		if (state_q == ST_FILT2) acc_q <= prod_s1[SUM_W-1:0];
		if (out_load) begin
			position_value_q <= pos_q;
			speed_raw_q      <= prev_speed_q;
			speed_filtered_q <= filt_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign position_value = position_value_q;
	assign speed_raw      = speed_raw_q;
	assign speed_filtered = speed_filtered_q;

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input taken while a word is in progress");

	a_div_only_divw: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIVW))
		else $error("divider finished outside its wait state");

	a_load_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("stalled result dropped");

endmodule
